### design/clns_pkg.sv
// Shared types, request codes and constant tables for the character LCD nibble sequencer.
package clns_pkg;

  localparam int CmdW    = 3;
  localparam int ByteW   = 8;
  localparam int ColW    = 6;
  localparam int RowW    = 3;
  localparam int NibW    = 4;
  localparam int WaitW   = 6;
  localparam int PhaseW  = 2;
  localparam int IdxW    = 3;

  localparam logic [CmdW-1:0] CMD_COMMAND = 3'd0;
  localparam logic [CmdW-1:0] CMD_DATA    = 3'd1;
  localparam logic [CmdW-1:0] CMD_SETPOS  = 3'd2;
  localparam logic [CmdW-1:0] CMD_CLEAR   = 3'd3;
  localparam logic [CmdW-1:0] CMD_INIT    = 3'd4;

  localparam logic [ByteW-1:0] DDRAM_SET   = 8'h80;
  localparam logic [ByteW-1:0] CLEAR_BYTE  = 8'h01;
  localparam logic [WaitW-1:0] POWERUP_MS  = 6'd40;
  localparam logic [WaitW-1:0] SETPOS_MS   = 6'd1;
  localparam logic [WaitW-1:0] CLEAR_MS    = 6'd2;
  localparam logic [WaitW-1:0] NIB3_MS     = 6'd1;
  localparam logic [NibW-1:0]  WAKE_NIB    = 4'h3;
  localparam logic [IdxW-1:0]  NIB3_COUNT  = 3'd3;
  localparam logic [IdxW-1:0]  INIT_BYTES  = 3'd6;

  // phase source for the datapath
  typedef enum logic [1:0] {
    K_POWER,
    K_NIB3,
    K_REQ_BYTE,
    K_INIT_BYTE
  } kind_t;

  // controller to datapath command for one phase
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [PhaseW-1:0] phase;
    logic [IdxW-1:0]   idx;
    logic              last;
  } ctl_t;

  function automatic logic [ByteW-1:0] row_base(input logic [1:0] r);
    logic [ByteW-1:0] b;
    unique case (r)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

  function automatic logic [ByteW-1:0] init_byte(input logic [IdxW-1:0] i);
    logic [ByteW-1:0] b;
    unique case (i)
      3'd0:    b = 8'h28;
      3'd1:    b = 8'h28;
      3'd2:    b = 8'h0C;
      3'd3:    b = 8'h01;
      3'd4:    b = 8'h06;
      default: b = 8'h02;
    endcase
    return b;
  endfunction

  function automatic logic [WaitW-1:0] init_wait(input logic [IdxW-1:0] i);
    logic [WaitW-1:0] w;
    unique case (i)
      3'd3:    w = 6'd2;
      3'd5:    w = 6'd2;
      default: w = 6'd1;
    endcase
    return w;
  endfunction

endpackage

### design/clns_ctrl.sv
// Phase sequencing state machine for the character LCD nibble sequencer.
module clns_ctrl import clns_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [CmdW-1:0] cmd,
  input  logic [RowW-1:0] row,
  output logic            busy,
  output logic            load,
  output ctl_t            ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POWER,
    S_NIB3,
    S_BYTE
  } state_t;

  state_t            state;
  logic              init_run;
  logic [PhaseW-1:0] phase;
  logic [IdxW-1:0]   idx;
  logic              byte_req;

  assign busy = (state != S_IDLE);
  assign load = start && (state == S_IDLE);

  always_comb begin
    byte_req = 1'b0;
    unique case (cmd) inside
      CMD_COMMAND, CMD_DATA, CMD_CLEAR: byte_req = 1'b1;
      CMD_SETPOS:                       byte_req = (row[RowW-1:2] == '0);
      default:                          byte_req = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      init_run  <= 1'b0;
      phase     <= '0;
      idx       <= '0;
      ctl.valid <= 1'b0;
      ctl.kind  <= K_POWER;
      ctl.phase <= '0;
      ctl.idx   <= '0;
      ctl.last  <= 1'b0;
    end else begin
      ctl.valid <= 1'b0;
      ctl.last  <= 1'b0;
      ctl.phase <= phase;
      ctl.idx   <= idx;
      unique case (state)
        S_IDLE: begin
          phase <= '0;
          idx   <= '0;
          if (start) begin
            if (cmd == CMD_INIT) begin
              state    <= S_POWER;
              init_run <= 1'b1;
            end else if (byte_req) begin
              state    <= S_BYTE;
              init_run <= 1'b0;
            end
          end
        end
        S_POWER: begin
          ctl.valid <= 1'b1;
          ctl.kind  <= K_POWER;
          state     <= S_NIB3;
        end
        S_NIB3: begin
          ctl.valid <= 1'b1;
          ctl.kind  <= K_NIB3;
          if (phase[0]) begin
            phase <= '0;
            if (idx == NIB3_COUNT - 3'd1) begin
              idx   <= '0;
              state <= S_BYTE;
            end else begin
              idx <= idx + 3'd1;
            end
          end else begin
            phase <= phase + 2'd1;
          end
        end
        S_BYTE: begin
          ctl.valid <= 1'b1;
          ctl.kind  <= init_run ? K_INIT_BYTE : K_REQ_BYTE;
          phase     <= phase + 2'd1;
          if (phase == 2'd3) begin
            if (!init_run || idx == INIT_BYTES - 3'd1) begin
              ctl.last <= 1'b1;
              state    <= S_IDLE;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/clns_dpath.sv
// Request byte register and phase field generation for the nibble sequencer.
module clns_dpath import clns_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [CmdW-1:0]  cmd,
  input  logic [ByteW-1:0] byte_value,
  input  logic [ColW-1:0]  column,
  input  logic [RowW-1:0]  row,
  input  ctl_t             ctl,
  output logic             strobe,
  output logic             reg_select,
  output logic [NibW-1:0]  nibble,
  output logic             enable,
  output logic             short_wait,
  output logic [WaitW-1:0] wait_ms,
  output logic             last
);

  logic [ByteW-1:0] req_byte;
  logic             req_rs;
  logic [WaitW-1:0] req_wait;

  logic [ByteW-1:0] req_byte_next;
  logic             req_rs_next;
  logic [WaitW-1:0] req_wait_next;

  logic [ByteW-1:0] cur_byte;
  logic             rs_next;
  logic [NibW-1:0]  nib_next;
  logic             en_next;
  logic [WaitW-1:0] wait_next;

  // latch the byte of a simple request
  always_comb begin
    req_byte_next = byte_value;
    req_rs_next   = 1'b0;
    req_wait_next = '0;
    unique case (cmd)
      CMD_DATA: req_rs_next = 1'b1;
      CMD_SETPOS: begin
        req_byte_next = (row_base(row[1:0]) + {2'b00, column}) | DDRAM_SET;
        req_wait_next = SETPOS_MS;
      end
      CMD_CLEAR: begin
        req_byte_next = CLEAR_BYTE;
        req_wait_next = CLEAR_MS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req_byte <= req_byte_next;
      req_rs   <= req_rs_next;
      req_wait <= req_wait_next;
    end
  end

  // phase fields; byte phases send the high nibble in phases 0 and 1, enable high on even phases but not at power-up
  always_comb begin
    cur_byte  = (ctl.kind == K_INIT_BYTE) ? init_byte(ctl.idx) : req_byte;
    rs_next   = 1'b0;
    nib_next  = ctl.phase[1] ? cur_byte[NibW-1:0] : cur_byte[ByteW-1:NibW];
    en_next   = !ctl.phase[0];
    wait_next = '0;
    unique case (ctl.kind)
      K_POWER: begin
        nib_next  = '0;
        en_next   = 1'b0;
        wait_next = POWERUP_MS;
      end
      K_NIB3: begin
        nib_next  = WAKE_NIB;
        wait_next = ctl.phase[0] ? NIB3_MS : '0;
      end
      K_REQ_BYTE: begin
        rs_next   = req_rs;
        wait_next = (ctl.phase == 2'd3) ? req_wait : '0;
      end
      default: begin
        wait_next = (ctl.phase == 2'd3) ? init_wait(ctl.idx) : '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    reg_select <= rs_next;
    nibble     <= nib_next;
    enable     <= en_next;
    short_wait <= en_next;
    wait_ms    <= wait_next;
    last       <= ctl.last;
  end

endmodule

### design/char_lcd_nibble_sequencer.sv
// Top level of the 4-bit character LCD nibble sequencer.
//
//   channel  | handshake          | fields
//   ---------+--------------------+----------------------------------------------
//   request  | start, busy        | cmd, byte_value, column, row
//   phase    | strobe (no stall)  | reg_select, nibble, enable, short_wait,
//            |                    | wait_ms, last
//
// An item is taken when start is high and busy is low. The controller then
// issues one phase per cycle; each phase is registered in the datapath and
// appears on the outputs for a single cycle with strobe high. Byte requests
// give four phases, initialise gives 31; busy stays high until the last
// phase has been issued, so no new request is taken before then. Set position
// to rows 4 to 7 and unknown codes give no phases. Synchronous reset returns
// the controller to idle and drops strobe. The receiver cannot stall.
module char_lcd_nibble_sequencer import clns_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [CmdW-1:0]  cmd,
  input  logic [ByteW-1:0] byte_value,
  input  logic [ColW-1:0]  column,
  input  logic [RowW-1:0]  row,
  output logic             strobe,
  output logic             reg_select,
  output logic [NibW-1:0]  nibble,
  output logic             enable,
  output logic             short_wait,
  output logic [WaitW-1:0] wait_ms,
  output logic             last
);

  logic load;   // item accepted this cycle
  ctl_t ctl;    // per-phase command into the datapath

  clns_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .row   (row),
    .busy  (busy),
    .load  (load),
    .ctl   (ctl)
  );

  clns_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .cmd        (cmd),
    .byte_value (byte_value),
    .column     (column),
    .row        (row),
    .ctl        (ctl),
    .strobe     (strobe),
    .reg_select (reg_select),
    .nibble     (nibble),
    .enable     (enable),
    .short_wait (short_wait),
    .wait_ms    (wait_ms),
    .last       (last)
  );

endmodule
